/* rtl/core/gemm_opt_pkg.sv */
// ----------------------------------------------------------------------------
// gemm_opt_pkg
// Shared types and constants for the 4x4 outer-product GEMM tile core.
// ----------------------------------------------------------------------------
`default_nettype none

package gemm_opt_pkg;

   // Tile geometry
   localparam int TILE_ROWS = 4;
   localparam int TILE_COLS = 4;
   localparam int LANES     = 4;
   localparam int CELLS     = TILE_ROWS * TILE_COLS;

   // Data widths
   localparam int OPND_W = 16;   // Q4.12 operands and gains
   localparam int CVAL_W = 32;   // Q8.24 C element
   localparam int ACC_W  = 48;   // Q24.24 accumulator
   localparam int POS_W  = 2;    // tile row or column index

   // Q4.12 unity and zero gains, and the 12-bit fraction shift
   localparam logic signed [OPND_W-1:0] GAIN_ONE   = 16'sd4096;
   localparam logic signed [OPND_W-1:0] GAIN_ZERO  = 16'sd0;
   localparam int                       FRAC_BITS  = 12;

   // Configuration register indexes (decoded from paddr[2])
   localparam logic REG_ALPHA = 1'b0;
   localparam logic REG_BETA  = 1'b1;

   // Item kinds
   typedef enum logic [1:0] {
      CMD_CLEAR   = 2'd0,
      CMD_ACCUM   = 2'd1,
      CMD_COMBINE = 2'd2
   } cmd_type;

   // One slot of the cell chain: the item plus the accumulator it picked up
   typedef struct packed {
      logic                          valid;
      cmd_type                       cmd;
      logic [LANES-1:0][OPND_W-1:0]  a;
      logic [LANES-1:0][OPND_W-1:0]  b;
      logic [CVAL_W-1:0]             c_old;
      logic [POS_W-1:0]              row;
      logic [POS_W-1:0]              col;
      logic [ACC_W-1:0]              acc;
   } stage_type;

   // Result handed from the combine tail to the output
   typedef struct packed {
      logic              valid;
      logic [CVAL_W-1:0] c_new;
      logic [POS_W-1:0]  row;
      logic [POS_W-1:0]  col;
   } result_type;

endpackage

`default_nettype wire

/* rtl/core/gemm_opt_cell.sv */
// ----------------------------------------------------------------------------
// gemm_opt_cell
// One MAC cell of the chain. Holds a single tile accumulator, applies clear
// and accumulate items as they pass, and lets a combine item for its
// position pick up the accumulator. Hands the item to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module gemm_opt_cell (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         advance,
   input  wire logic [gemm_opt_pkg::POS_W-1:0] cell_row,
   input  wire logic [gemm_opt_pkg::POS_W-1:0] cell_col,
   input  wire gemm_opt_pkg::stage_type      prev_stage,
   output      gemm_opt_pkg::stage_type      next_stage
);
   import gemm_opt_pkg::*;

   logic signed [ACC_W-1:0]          acc_ff;
   logic signed [ACC_W-1:0]          acc_in;
   stage_type                        stage_ff;
   stage_type                        stage_in;
   logic signed [2*OPND_W-1:0]       prod;
   logic signed [ACC_W:0]            sum;
   logic signed [ACC_W-1:0]          sum_sat;
   logic                             hit;

   // Product of this cell's A row and B column lanes
   assign prod = $signed(prev_stage.a[cell_row]) * $signed(prev_stage.b[cell_col]);

   // Accumulate with saturation at the 48-bit range
   always_comb begin
      sum = {acc_ff[ACC_W-1], acc_ff} + {{(ACC_W+1-2*OPND_W){prod[2*OPND_W-1]}}, prod};
      if (sum[ACC_W] != sum[ACC_W-1]) begin
         sum_sat = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      end else begin
         sum_sat = sum[ACC_W-1:0];
      end
   end

   assign hit = (prev_stage.row == cell_row) && (prev_stage.col == cell_col);

   // Accumulator update and pick-up of the value by a passing combine
   always_comb begin
      acc_in   = acc_ff;
      stage_in = prev_stage;
      if (prev_stage.valid) begin
         unique case (prev_stage.cmd)
            CMD_CLEAR:   acc_in = '0;
            CMD_ACCUM:   acc_in = sum_sat;
            CMD_COMBINE: begin
               if (hit) begin
                  stage_in.acc = acc_ff;
               end
            end
            default:     acc_in = acc_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff         <= '0;
         stage_ff.valid <= 1'b0;
      end else if (advance) begin
         acc_ff         <= acc_in;
         stage_ff.valid <= stage_in.valid;
      end
   end

   // Payload of the slot, no reset
   always_ff @(posedge clock) begin
      if (advance) begin
         stage_ff.cmd   <= stage_in.cmd;
         stage_ff.a     <= stage_in.a;
         stage_ff.b     <= stage_in.b;
         stage_ff.c_old <= stage_in.c_old;
         stage_ff.row   <= stage_in.row;
         stage_ff.col   <= stage_in.col;
         stage_ff.acc   <= stage_in.acc;
      end
   end

   assign next_stage = stage_ff;

endmodule

`default_nettype wire

/* rtl/core/gemm_opt_combine.sv */
// ----------------------------------------------------------------------------
// gemm_opt_combine
// Three-stage tail: gain products, rounding and gain bypass, then the sum
// of both terms saturated to 32 bits into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module gemm_opt_combine (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 advance,
   input  wire gemm_opt_pkg::stage_type              chain_stage,
   input  wire logic signed [gemm_opt_pkg::OPND_W-1:0] alpha_gain,
   input  wire logic signed [gemm_opt_pkg::OPND_W-1:0] beta_gain,
   output      gemm_opt_pkg::result_type             result
);
   import gemm_opt_pkg::*;

   localparam int PB_W = CVAL_W + OPND_W;        // beta product
   localparam int PA_W = ACC_W + OPND_W;         // alpha product
   localparam int T1_W = PB_W - FRAC_BITS;
   localparam int T2_W = PA_W - FRAC_BITS;
   localparam int S_W  = T2_W + 1;

   // Stage 1: products
   logic                     s1_valid_ff;
   logic signed [PB_W-1:0]   s1_pbeta_ff;
   logic signed [PA_W-1:0]   s1_palpha_ff;
   logic signed [CVAL_W-1:0] s1_cold_ff;
   logic signed [ACC_W-1:0]  s1_acc_ff;
   logic [POS_W-1:0]         s1_row_ff;
   logic [POS_W-1:0]         s1_col_ff;
   logic                     s1_valid_in;

   // Stage 2: scaled terms
   logic                     s2_valid_ff;
   logic signed [T1_W-1:0]   s2_t1_ff;
   logic signed [T2_W-1:0]   s2_t2_ff;
   logic [POS_W-1:0]         s2_row_ff;
   logic [POS_W-1:0]         s2_col_ff;
   logic signed [T1_W-1:0]   s2_t1_in;
   logic signed [T2_W-1:0]   s2_t2_in;
   logic signed [PB_W-1:0]   pbeta_rnd;
   logic signed [PA_W-1:0]   palpha_rnd;

   // Stage 3: output register
   logic                     out_valid_ff;
   logic [CVAL_W-1:0]        out_cnew_ff;
   logic [POS_W-1:0]         out_row_ff;
   logic [POS_W-1:0]         out_col_ff;
   logic signed [S_W-1:0]    sum;
   logic [CVAL_W-1:0]        sum_sat;

   assign s1_valid_in = chain_stage.valid && (chain_stage.cmd == CMD_COMBINE);

   // Rounding (round half up) and gain bypass
   always_comb begin
      pbeta_rnd  = s1_pbeta_ff + PB_W'(1 << (FRAC_BITS - 1));
      palpha_rnd = s1_palpha_ff + PA_W'(1 << (FRAC_BITS - 1));
      priority if (beta_gain == GAIN_ZERO) begin
         s2_t1_in = '0;
      end else if (beta_gain == GAIN_ONE) begin
         s2_t1_in = T1_W'(s1_cold_ff);
      end else begin
         s2_t1_in = pbeta_rnd[PB_W-1:FRAC_BITS];
      end
      if (alpha_gain == GAIN_ONE) begin
         s2_t2_in = T2_W'(s1_acc_ff);
      end else begin
         s2_t2_in = palpha_rnd[PA_W-1:FRAC_BITS];
      end
   end

   // Exact sum, then saturation to 32 bits
   always_comb begin
      sum = S_W'(s2_t1_ff) + S_W'(s2_t2_ff);
      if (sum > S_W'(signed'({1'b0, {(CVAL_W-1){1'b1}}}))) begin
         sum_sat = {1'b0, {(CVAL_W-1){1'b1}}};
      end else if (sum < -S_W'(signed'({1'b0, 1'b1, {(CVAL_W-1){1'b0}}}))) begin
         sum_sat = {1'b1, {(CVAL_W-1){1'b0}}};
      end else begin
         sum_sat = sum[CVAL_W-1:0];
      end
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s1_valid_ff;
         out_valid_ff <= s2_valid_ff;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_pbeta_ff  <= $signed(chain_stage.c_old) * beta_gain;
         s1_palpha_ff <= $signed(chain_stage.acc) * alpha_gain;
         s1_cold_ff   <= chain_stage.c_old;
         s1_acc_ff    <= chain_stage.acc;
         s1_row_ff    <= chain_stage.row;
         s1_col_ff    <= chain_stage.col;
         s2_t1_ff     <= s2_t1_in;
         s2_t2_ff     <= s2_t2_in;
         s2_row_ff    <= s1_row_ff;
         s2_col_ff    <= s1_col_ff;
         out_cnew_ff  <= sum_sat;
         out_row_ff   <= s2_row_ff;
         out_col_ff   <= s2_col_ff;
      end
   end

   assign result.valid = out_valid_ff;
   assign result.c_new = out_cnew_ff;
   assign result.row   = out_row_ff;
   assign result.col   = out_col_ff;

endmodule

`default_nettype wire

/* rtl/core/gemm_outer_product_tile_core.sv */
// ----------------------------------------------------------------------------
// gemm_outer_product_tile_core
// 4x4 outer-product GEMM micro-kernel tile: a chain of 16 MAC cells, one per
// accumulator, followed by a three-stage alpha/beta combine tail.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle unless a stalled result holds the pipeline;
//   every item walks the 16-cell chain in order: 16 cell stages, the first
//   loaded at the transfer edge, then 3 tail stages up to the output register.
// A stalled result holds the whole pipeline; input is taken whenever the
//   output register is empty or being drained.
// Reset: accumulators zero, alpha_gain 1.0, beta_gain 0, pipeline empty.
// ----------------------------------------------------------------------------
`default_nettype none

module gemm_outer_product_tile_core (
   input  wire logic          clock,
   input  wire logic          reset,
   // Input stream
   input  wire logic          req_tvalid,
   output      logic          req_tready,
   // tdata: a_elem0..3 [63:0], b_elem0..3 [127:64], c_old [159:128],
   //        elem_row [161:160], elem_col [163:162], zero pad [167:164]
   input  wire logic [167:0]  req_tdata,
   // tuser: cmd [1:0]
   input  wire logic [1:0]    req_tuser,
   // Result stream
   output      logic          rsp_tvalid,
   input  wire logic          rsp_tready,
   // tdata: c_new [31:0], out_row [33:32], out_col [35:34], zero pad [39:36]
   output      logic [39:0]   rsp_tdata,
   // Configuration port
   input  wire logic          csr_psel,
   input  wire logic          csr_penable,
   input  wire logic          csr_pwrite,
   input  wire logic [2:0]    csr_paddr,
   input  wire logic [31:0]   csr_pwdata,
   output      logic [31:0]   csr_prdata,
   output      logic          csr_pready
);
   import gemm_opt_pkg::*;

   logic signed [OPND_W-1:0] alpha_ff;
   logic signed [OPND_W-1:0] beta_ff;
   logic                     csr_write;
   logic                     advance;
   stage_type                chain [CELLS+1];
   result_type               result;

   // Configuration registers
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= GAIN_ONE;
         beta_ff  <= GAIN_ZERO;
      end else if (csr_write) begin
         unique case (csr_paddr[2])
            REG_ALPHA: alpha_ff <= csr_pwdata[OPND_W-1:0];
            REG_BETA:  beta_ff  <= csr_pwdata[OPND_W-1:0];
            default:   alpha_ff <= alpha_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_ALPHA: csr_prdata = 32'(alpha_ff);
         REG_BETA:  csr_prdata = 32'(beta_ff);
         default:   csr_prdata = '0;
      endcase
   end

   // Whole pipeline moves when the output register can take a new value
   assign advance    = !result.valid || rsp_tready;
   assign req_tready = advance;

   // Chain entry built from the input transfer
   always_comb begin
      chain[0].valid = req_tvalid;
      chain[0].cmd   = cmd_type'(req_tuser);
      for (int i = 0; i < LANES; i++) begin
         chain[0].a[i] = req_tdata[i*OPND_W +: OPND_W];
         chain[0].b[i] = req_tdata[(LANES+i)*OPND_W +: OPND_W];
      end
      chain[0].c_old = req_tdata[2*LANES*OPND_W +: CVAL_W];
      chain[0].row   = req_tdata[2*LANES*OPND_W+CVAL_W +: POS_W];
      chain[0].col   = req_tdata[2*LANES*OPND_W+CVAL_W+POS_W +: POS_W];
      chain[0].acc   = '0;
   end

   // Row of MAC cells, one per accumulator
   for (genvar k = 0; k < CELLS; k++) begin : g_cell
      gemm_opt_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .advance    (advance),
         .cell_row   (POS_W'(k / TILE_COLS)),
         .cell_col   (POS_W'(k % TILE_COLS)),
         .prev_stage (chain[k]),
         .next_stage (chain[k+1])
      );
   end

   // Combine tail and output register
   gemm_opt_combine u_combine (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .chain_stage (chain[CELLS]),
      .alpha_gain  (alpha_ff),
      .beta_gain   (beta_ff),
      .result      (result)
   );

   assign rsp_tvalid = result.valid;
   assign rsp_tdata  = {4'b0000, result.col, result.row, result.c_new};

endmodule

`default_nettype wire

/* bench/gemm_tile_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gemm_tile_checker
// Watches the item, result and register ports of the 4x4 outer-product tile.
// Keeps its own copy of the accumulators and gains, predicts each combine
// result at input transfer time and compares it with the results in order.
// ----------------------------------------------------------------------------

module gemm_tile_checker (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   input  wire logic          req_tready,
   // tdata: a_elem0..3, b_elem0..3, c_old, elem_row, elem_col, zero pad
   input  wire logic [167:0]  req_tdata,
   // tuser: cmd
   input  wire logic [1:0]    req_tuser,
   input  wire logic          rsp_tvalid,
   input  wire logic          rsp_tready,
   // tdata: c_new, out_row, out_col, zero pad
   input  wire logic [39:0]   rsp_tdata,
   input  wire logic          csr_psel,
   input  wire logic          csr_penable,
   input  wire logic          csr_pwrite,
   input  wire logic [2:0]    csr_paddr,
   input  wire logic [31:0]   csr_pwdata,
   input  wire logic          csr_pready,
   output int                 mismatch_count,
   output int                 outstanding
);
   import gemm_opt_pkg::*;

   // Field offsets inside req_tdata
   localparam int B_LSB    = LANES * OPND_W;
   localparam int COLD_LSB = 2 * LANES * OPND_W;
   localparam int ROW_LSB  = COLD_LSB + CVAL_W;
   localparam int COL_LSB  = ROW_LSB + POS_W;

   localparam longint ACC_HI  = (longint'(1) <<< (ACC_W - 1)) - 1;
   localparam longint ACC_LO  = -(longint'(1) <<< (ACC_W - 1));
   localparam longint CVAL_HI = (longint'(1) <<< (CVAL_W - 1)) - 1;
   localparam longint CVAL_LO = -(longint'(1) <<< (CVAL_W - 1));

   typedef struct packed {
      logic [CVAL_W-1:0] c_new;
      logic [POS_W-1:0]  row;
      logic [POS_W-1:0]  col;
   } element_result_type;

   // Shadow state of the tile
   longint                   tile_acc [TILE_ROWS][TILE_COLS];
   logic signed [OPND_W-1:0] alpha_q12;
   logic signed [OPND_W-1:0] beta_q12;
   element_result_type       pending_elements [$];
   int                       errors_seen = 0;

   // Scratch for one edge
   logic signed [OPND_W-1:0] a_col [LANES];
   logic signed [OPND_W-1:0] b_row [LANES];
   logic [POS_W-1:0]         pos_row, pos_col;
   longint                   cell_acc;
   element_result_type       predicted, observed;

   initial begin
      mismatch_count = 0;
      outstanding    = 0;
   end

   function automatic longint saturate_acc(longint value);
      if (value > ACC_HI) return ACC_HI;
      if (value < ACC_LO) return ACC_LO;
      return value;
   endfunction

   // Q8.24 value times Q4.12 gain, rounded half up back to Q8.24
   function automatic longint apply_gain_q12(longint value, logic signed [OPND_W-1:0] gain);
      return (value * longint'(gain) + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
   endfunction

   function automatic logic [CVAL_W-1:0] combine_element(longint acc,
                                                         logic signed [CVAL_W-1:0] c_prior);
      longint old_term;
      longint acc_term;
      longint total;
      if (beta_q12 == GAIN_ZERO)
         old_term = 0;
      else if (beta_q12 == GAIN_ONE)
         old_term = c_prior;
      else
         old_term = apply_gain_q12(c_prior, beta_q12);
      if (alpha_q12 == GAIN_ONE)
         acc_term = acc;
      else
         acc_term = apply_gain_q12(acc, alpha_q12);
      total = old_term + acc_term;
      if (total > CVAL_HI) total = CVAL_HI;
      if (total < CVAL_LO) total = CVAL_LO;
      return total[CVAL_W-1:0];
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         foreach (tile_acc[r, c]) tile_acc[r][c] = 0;
         alpha_q12 = GAIN_ONE;
         beta_q12  = GAIN_ZERO;
         pending_elements.delete();
      end else begin
         // Register write
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[2] == REG_ALPHA)
               alpha_q12 = csr_pwdata[OPND_W-1:0];
            else
               beta_q12 = csr_pwdata[OPND_W-1:0];
         end

         // Input transfer: update the shadow tile, queue combine results
         if (req_tvalid && req_tready) begin
            case (req_tuser)
               CMD_CLEAR: begin
                  foreach (tile_acc[r, c]) tile_acc[r][c] = 0;
               end
               CMD_ACCUM: begin
                  for (int l = 0; l < LANES; l++) begin
                     a_col[l] = req_tdata[OPND_W*l +: OPND_W];
                     b_row[l] = req_tdata[B_LSB + OPND_W*l +: OPND_W];
                  end
                  for (int r = 0; r < TILE_ROWS && r < LANES; r++)
                     for (int c = 0; c < TILE_COLS && c < LANES; c++)
                        tile_acc[r][c] = saturate_acc(tile_acc[r][c]
                                         + longint'(a_col[r]) * longint'(b_row[c]));
               end
               CMD_COMBINE: begin
                  pos_row = req_tdata[ROW_LSB +: POS_W];
                  pos_col = req_tdata[COL_LSB +: POS_W];
                  // positions outside the tile read as zero
                  if (pos_row < TILE_ROWS && pos_col < TILE_COLS)
                     cell_acc = tile_acc[pos_row][pos_col];
                  else
                     cell_acc = 0;
                  predicted.c_new = combine_element(cell_acc,
                                                    $signed(req_tdata[COLD_LSB +: CVAL_W]));
                  predicted.row   = pos_row;
                  predicted.col   = pos_col;
                  pending_elements.push_back(predicted);
               end
               default: ;  // unused code: no effect
            endcase
         end

         // Result transfer: compare against the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            observed.c_new = rsp_tdata[CVAL_W-1:0];
            observed.row   = rsp_tdata[CVAL_W +: POS_W];
            observed.col   = rsp_tdata[CVAL_W + POS_W +: POS_W];
            if (pending_elements.size() == 0) begin
               $error("unexpected result: c_new %0d, out_row %0d, out_col %0d",
                      $signed(observed.c_new), observed.row, observed.col);
               errors_seen++;
            end else begin
               predicted = pending_elements.pop_front();
               if (observed.c_new !== predicted.c_new) begin
                  $error("c_new mismatch: expected %0d, actual %0d",
                         $signed(predicted.c_new), $signed(observed.c_new));
                  errors_seen++;
               end
               if (observed.row !== predicted.row) begin
                  $error("out_row mismatch: expected %0d, actual %0d",
                         predicted.row, observed.row);
                  errors_seen++;
               end
               if (observed.col !== predicted.col) begin
                  $error("out_col mismatch: expected %0d, actual %0d",
                         predicted.col, observed.col);
                  errors_seen++;
               end
            end
         end
      end
      mismatch_count <= errors_seen;
      outstanding    <= pending_elements.size();
   end

endmodule

/* bench/tb_gemm_outer_product_tile_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gemm_outer_product_tile_core
// Drives clear, accumulate and combine items into the 4x4 GEMM tile core,
// reprograms alpha/beta between drained phases, and applies random source
// gaps and sink stalls. The checker predicts and compares every result.
// ----------------------------------------------------------------------------

module tb_gemm_outer_product_tile_core;
   import gemm_opt_pkg::*;

   localparam int          RESET_CYCLES   = 6;
   localparam int          DRAIN_CYCLES   = 24;    // pipeline is 19 deep
   localparam int          WATCHDOG_LIMIT = 4000;
   localparam int          PHASE_ITEMS    = 240;
   localparam logic [1:0]  CMD_UNUSED     = 2'd3;

   logic          clock = 1'b0;
   logic          reset;
   logic          req_tvalid;
   logic          req_tready;
   logic [167:0]  req_tdata;   // a_elem0..3, b_elem0..3, c_old, elem_row, elem_col, pad
   logic [1:0]    req_tuser;   // cmd
   logic          rsp_tvalid;
   logic          rsp_tready;
   logic [39:0]   rsp_tdata;   // c_new, out_row, out_col, pad
   logic          csr_psel;
   logic          csr_penable;
   logic          csr_pwrite;
   logic [2:0]    csr_paddr;
   logic [31:0]   csr_pwdata;
   logic [31:0]   csr_prdata;
   logic          csr_pready;

   int            mismatch_count;
   int            outstanding;
   int            send_idle_pct;
   int            recv_stall_pct;
   int            idle_cycles = 0;

   always #6 clock = ~clock;

   gemm_outer_product_tile_core uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   gemm_tile_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_pready     (csr_pready),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   // Sink back-pressure
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Watchdog: cycles without any transfer or register write
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable && csr_pwrite && csr_pready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic logic [167:0] tile_payload(logic [LANES-1:0][OPND_W-1:0] a_col,
                                                 logic [LANES-1:0][OPND_W-1:0] b_row,
                                                 logic [CVAL_W-1:0] c_prior,
                                                 logic [POS_W-1:0] row,
                                                 logic [POS_W-1:0] col);
      return {4'b0000, col, row, c_prior, b_row, a_col};
   endfunction

   // Mix of small values, corners and full-range values
   function automatic logic [OPND_W-1:0] rand_operand();
      logic [OPND_W-1:0] v;
      case ($urandom_range(3))
         0: v = OPND_W'($urandom_range(8191)) - 16'd4096;
         1: begin
            case ($urandom_range(4))
               0: v = 16'h8000;
               1: v = 16'h7fff;
               2: v = 16'h0000;
               3: v = 16'hffff;
               default: v = 16'h0001;
            endcase
         end
         default: v = OPND_W'($urandom_range(16'hffff));
      endcase
      return v;
   endfunction

   function automatic logic [LANES-1:0][OPND_W-1:0] rand_lanes();
      logic [LANES-1:0][OPND_W-1:0] v;
      for (int l = 0; l < LANES; l++) v[l] = rand_operand();
      return v;
   endfunction

   function automatic logic [CVAL_W-1:0] rand_cold();
      logic [CVAL_W-1:0] v;
      case ($urandom_range(2))
         0: begin
            case ($urandom_range(4))
               0: v = 32'h8000_0000;
               1: v = 32'h7fff_ffff;
               2: v = 32'h0000_0000;
               3: v = 32'hffff_ffff;
               default: v = 32'h0000_0001;
            endcase
         end
         1: v = $urandom_range(32'h0200_0000) - 32'h0100_0000;
         default: v = $urandom;
      endcase
      return v;
   endfunction

   function automatic logic [167:0] rand_payload();
      return tile_payload(rand_lanes(), rand_lanes(), rand_cold(),
                          POS_W'($urandom_range(3)), POS_W'($urandom_range(3)));
   endfunction

   // One item transfer; entered and left at a falling edge
   task automatic send_item(input logic [1:0] kind, input logic [167:0] payload);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= payload;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_combine(input logic [CVAL_W-1:0] c_prior,
                               input logic [POS_W-1:0] row, input logic [POS_W-1:0] col);
      send_item(CMD_COMBINE, tile_payload(rand_lanes(), rand_lanes(), c_prior, row, col));
   endtask

   // Wait until every predicted result has been taken, plus pipeline depth
   task automatic drain_tile();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   // Register write: setup then access cycle; upper data bits are don't-care
   task automatic write_gain(input logic sel, input logic [OPND_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {sel, 2'b00};
      csr_pwdata  <= {16'($urandom_range(16'hffff)), value};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic set_gains(input logic [OPND_W-1:0] alpha, input logic [OPND_W-1:0] beta);
      drain_tile();
      write_gain(REG_ALPHA, alpha);
      write_gain(REG_BETA, beta);
   endtask

   task automatic set_idle_mode(input int mode);
      case (mode)
         0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
         default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase
   endtask

   // Mostly clear / accumulate run / combine reads, some raw noise
   task automatic run_tile_bursts(input int item_goal);
      int         sent;
      int         depth;
      int         reads;
      int         noise;
      logic [1:0] kind;
      sent = 0;
      while (sent < item_goal) begin
         if ($urandom_range(99) < 80) begin
            send_item(CMD_CLEAR, rand_payload());
            if ($urandom_range(99) < 5)
               depth = $urandom_range(1, 384);
            else
               depth = $urandom_range(1, 24);
            repeat (depth) send_item(CMD_ACCUM, rand_payload());
            reads = $urandom_range(1, 8);
            repeat (reads) send_item(CMD_COMBINE, rand_payload());
            sent += 1 + depth + reads;
         end else begin
            noise = $urandom_range(1, 6);
            repeat (noise) begin
               kind = 2'($urandom_range(3));
               send_item(kind, rand_payload());
               if (kind != CMD_UNUSED) sent++;
            end
         end
      end
   endtask

   initial begin
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      req_tuser      = CMD_CLEAR;
      rsp_tready     = 1'b0;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = '0;
      csr_pwdata     = '0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: reset gains, beta zero ignores c_old, corner operands
      set_idle_mode(0);
      send_combine(32'h7fff_ffff, 2'd0, 2'd0);
      send_item(CMD_ACCUM, tile_payload({4{16'h8000}}, {4{16'h8000}}, '0, '0, '0));
      send_item(CMD_ACCUM, tile_payload({4{16'h7fff}}, {4{16'h7fff}}, '0, '0, '0));
      send_item(CMD_ACCUM, tile_payload({16'hffff, 16'h0001, 16'h7fff, 16'h8000},
                                        {16'h0000, 16'hffff, 16'h8000, 16'h7fff},
                                        '0, '0, '0));
      send_item(CMD_UNUSED, rand_payload());
      send_combine(rand_cold(), 2'd0, 2'd0);
      send_combine(rand_cold(), 2'd1, 2'd2);
      send_combine(rand_cold(), 2'd2, 2'd1);
      send_combine(rand_cold(), 2'd3, 2'd3);
      send_item(CMD_CLEAR, rand_payload());
      send_combine(32'h8000_0000, 2'd0, 2'd0);

      // Beta one passes c_old through, most negative alpha
      set_gains(16'h8000, GAIN_ONE);
      send_item(CMD_ACCUM, tile_payload({4{16'h8000}}, {4{16'h7fff}}, '0, '0, '0));
      send_combine(32'h8000_0000, 2'd0, 2'd0);
      send_combine(32'h7fff_ffff, 2'd3, 2'd3);
      send_item(CMD_ACCUM, rand_payload());
      send_combine(32'h0000_0001, 2'd1, 2'd1);

      // Both gains scaled, opposite extremes
      set_gains(16'h7fff, 16'h8000);
      send_combine(32'h7fff_ffff, 2'd2, 2'd2);
      send_combine(32'h8000_0000, 2'd0, 2'd3);
      send_combine(32'hffff_ffff, 2'd1, 2'd0);
      send_item(CMD_CLEAR, rand_payload());
      send_combine(rand_cold(), 2'd3, 2'd0);

      // Smallest gains: rounding of tiny products
      set_gains(16'h0001, 16'hffff);
      send_item(CMD_ACCUM, tile_payload({4{16'h0fff}}, {4{16'hf001}}, '0, '0, '0));
      send_combine(32'h0000_0800, 2'd2, 2'd3);
      send_combine(32'hffff_f7ff, 2'd0, 2'd1);

      // Random phases over several gain settings and idle patterns
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: set_gains(GAIN_ONE, GAIN_ZERO);
            1: set_gains(GAIN_ONE, GAIN_ONE);
            2: set_gains(16'h7fff, 16'h8000);
            3: set_gains(16'h8000, 16'h7fff);
            4: set_gains(OPND_W'($urandom_range(16'hffff)), OPND_W'($urandom_range(16'hffff)));
            5: set_gains(GAIN_ZERO, GAIN_ONE);
            6: set_gains(16'h0001, 16'hffff);
            default: set_gains(OPND_W'($urandom_range(16'hffff)), GAIN_ZERO);
         endcase
         set_idle_mode(phase % 4);
         run_tile_bursts(PHASE_ITEMS);
      end

      drain_tile();
      if (mismatch_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

/* files.f */
rtl/core/gemm_opt_pkg.sv
rtl/core/gemm_opt_cell.sv
rtl/core/gemm_opt_combine.sv
rtl/core/gemm_outer_product_tile_core.sv
bench/gemm_tile_checker.sv
bench/tb_gemm_outer_product_tile_core.sv
